@@ src/pair_id_lookup_or_allocate_macros.svh @@
// Assertion macros for the pair identifier table.
`ifndef PAIR_ID_LOOKUP_OR_ALLOCATE_MACROS_SVH
`define PAIR_ID_LOOKUP_OR_ALLOCATE_MACROS_SVH
`ifndef SYNTHESIS
`define PIDL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pidl: same-cycle check failed");
`define PIDL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pidl: next-cycle check failed");
`else
`define PIDL_ASSERT_SAME(label, ante, cons)
`define PIDL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/pidl_pkg.sv @@
// Shared types, constants and hash for the pair identifier table.
`default_nettype none
package pidl_pkg;

   localparam int unsigned CAPACITY    = 1024;
   localparam int unsigned IDX_W       = $clog2(CAPACITY);
   localparam int unsigned TABLE_DEPTH = 1 << IDX_W;
   localparam int unsigned COUNT_W     = $clog2(CAPACITY + 1);
   localparam int unsigned HASH_CHUNKS = (64 + IDX_W - 1) / IDX_W;

   localparam logic [31:0] NODE_RESET = 32'd1000;
   localparam logic [31:0] ID_RESET   = 32'd1;

   typedef enum logic [2:0] {
      OP_LOOKUP_CREATE = 3'd0,
      OP_LOOKUP        = 3'd1,
      OP_NEW_NODE      = 3'd2,
      OP_CLEAR         = 3'd3,
      OP_CLEAR_ALL     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NEW  = 2'd1,
      ST_MISS = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_START_NODE = 1'b0,
      CSR_START_ID   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] source_node;
      logic [31:0] target_node;
   } req_type;

   typedef struct packed {
      logic [31:0] answer_value;
      status_type  status;
   } rsp_type;

   // one table slot as stored in the RAM
   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [31:0] value;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        start;
      logic        clear;
      logic        create;
      logic        room;
      logic [63:0] key;
      logic [31:0] new_value;
   } tbl_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      status_type  status;
      logic [31:0] value;
   } tbl_rsp_type;

   // xor fold of the key down to a home slot
   function automatic logic [IDX_W-1:0] pidl_hash(input logic [63:0] key);
      logic [IDX_W-1:0] h;
      h = '0;
      for (int c = 0; c < HASH_CHUNKS; c++) begin
         h = h ^ IDX_W'(key >> (c * IDX_W));
      end
      return h;
   endfunction

endpackage
`default_nettype wire

@@ src/pair_id_lookup_or_allocate.sv @@
// Top level of the pair identifier table: counters, command decode, result register.
// Lookups: the S_PROBE answer is registered to the strobe; a further probe delays it.
// busy covers the probes, so the next transfer can be accepted in the strobe cycle.
// New node, unused opcodes: strobe in the cycle after accept, one per cycle unless busy.
// Clears sweep one slot a cycle, then the last slot's done is registered; no stalls.
// After reset the sweep runs busy; a command's counter update beats a CSR write.
`default_nettype none
`include "pair_id_lookup_or_allocate_macros.svh"
module pair_id_lookup_or_allocate
   import pidl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output      logic          busy,
   input  wire req_type       req_payload,
   output      logic          rsp_valid,
   output      rsp_type       rsp_payload,
   input  wire logic          csr_wr_en,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_wr_data
);

   logic               accept;
   logic               insert_done;
   tbl_cmd_type        tbl_cmd;
   tbl_rsp_type        tbl_rsp;

   logic [31:0]        node_ctr_ff, node_ctr_in;
   logic [31:0]        id_ctr_ff, id_ctr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   pidl_table u_table (
      .clock(clock),
      .reset(reset),
      .cmd  (tbl_cmd),
      .rsp  (tbl_rsp)
   );

   assign busy        = tbl_rsp.busy;
   assign accept      = start && !busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign insert_done = tbl_rsp.done && pend_ff && (tbl_rsp.status == ST_NEW);

   always_comb begin
      tbl_cmd.start     = accept && ((req_payload.opcode == OP_LOOKUP_CREATE) ||
                                     (req_payload.opcode == OP_LOOKUP) ||
                                     (req_payload.opcode == OP_CLEAR) ||
                                     (req_payload.opcode == OP_CLEAR_ALL));
      tbl_cmd.clear     = (req_payload.opcode == OP_CLEAR) ||
                          (req_payload.opcode == OP_CLEAR_ALL);
      tbl_cmd.create    = (req_payload.opcode == OP_LOOKUP_CREATE);
      tbl_cmd.room      = (count_ff != COUNT_W'(CAPACITY));
      tbl_cmd.key       = {req_payload.source_node, req_payload.target_node};
      tbl_cmd.new_value = id_ctr_ff;
   end

   always_comb begin
      node_ctr_in  = node_ctr_ff;
      id_ctr_in    = id_ctr_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_NODE: node_ctr_in = csr_wr_data;
            CSR_START_ID:   id_ctr_in   = csr_wr_data;
            default:        ;
         endcase
      end

      if (accept) begin
         unique case (req_payload.opcode)
            OP_LOOKUP_CREATE, OP_LOOKUP: begin
               pend_in = 1'b1;
            end
            OP_NEW_NODE: begin
               rsp_valid_in        = 1'b1;
               rsp_in.answer_value = node_ctr_ff;
               rsp_in.status       = ST_DONE;
               node_ctr_in         = node_ctr_ff + 32'd1;
            end
            OP_CLEAR: begin
               pend_in  = 1'b1;
               count_in = '0;
            end
            OP_CLEAR_ALL: begin
               pend_in     = 1'b1;
               count_in    = '0;
               id_ctr_in   = ID_RESET;
               node_ctr_in = NODE_RESET;
            end
            default: begin
               rsp_valid_in        = 1'b1;
               rsp_in.answer_value = '0;
               rsp_in.status       = ST_DONE;
            end
         endcase
      end

      // the sweep after reset also reports done; only a pending command answers
      if (tbl_rsp.done && pend_ff) begin
         pend_in             = 1'b0;
         rsp_valid_in        = 1'b1;
         rsp_in.answer_value = tbl_rsp.value;
         rsp_in.status       = tbl_rsp.status;
         if (tbl_rsp.status == ST_NEW) begin
            id_ctr_in = id_ctr_ff + 32'd1;
            count_in  = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         node_ctr_ff  <= NODE_RESET;
         id_ctr_ff    <= ID_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_ctr_ff  <= node_ctr_in;
         id_ctr_ff    <= id_ctr_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PIDL_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= COUNT_W'(CAPACITY))
   `PIDL_ASSERT_SAME(a_insert_has_room, insert_done, count_ff < COUNT_W'(CAPACITY))
   `PIDL_ASSERT_NEXT(a_table_cmd_busy, tbl_cmd.start, busy && pend_ff)
   `PIDL_ASSERT_SAME(a_rsp_when_table_idle, rsp_valid, !tbl_rsp.busy)

endmodule
`default_nettype wire

@@ src/pidl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pidl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ src/pidl_table.sv @@
// Hashed pair table: linear probing over one RAM, plus the clearing sweep.
`default_nettype none
module pidl_table
   import pidl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire tbl_cmd_type cmd,
   output      tbl_rsp_type rsp
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_CLEAR
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] probes_ff, probes_in;
   logic [63:0]      key_ff, key_in;
   logic             create_ff, create_in;
   logic             room_ff, room_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        rd_entry;
   logic             hit;
   logic             empty;
   logic             last;

   pidl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry = entry_type'(rd_data);
   assign hit      = rd_entry.valid && (rd_entry.key == key_ff);
   assign empty    = !rd_entry.valid;
   assign last     = (probes_ff == IDX_W'(TABLE_DEPTH - 1));

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      probes_in  = probes_ff;
      key_in     = key_ff;
      create_in  = create_ff;
      room_in    = room_ff;
      rd_addr    = idx_ff + IDX_W'(1);
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_entry   = '0;
      rsp.busy   = (state_ff != S_IDLE);
      rsp.done   = 1'b0;
      rsp.status = ST_DONE;
      rsp.value  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               if (cmd.clear) begin
                  idx_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  rd_addr   = pidl_hash(cmd.key);
                  idx_in    = pidl_hash(cmd.key);
                  probes_in = '0;
                  key_in    = cmd.key;
                  create_in = cmd.create;
                  room_in   = cmd.room;
                  state_in  = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            // read data for idx_ff is valid in this cycle
            if (hit) begin
               rsp.done   = 1'b1;
               rsp.value  = rd_entry.value;
               state_in   = S_IDLE;
            end else if (empty || last) begin
               rsp.done = 1'b1;
               state_in = S_IDLE;
               if (!create_ff) begin
                  rsp.status = ST_MISS;
               end else if (room_ff && empty) begin
                  wr_en          = 1'b1;
                  wr_entry.valid = 1'b1;
                  wr_entry.key   = key_ff;
                  wr_entry.value = cmd.new_value;
                  rsp.status     = ST_NEW;
                  rsp.value      = cmd.new_value;
               end else begin
                  rsp.status = ST_FULL;
               end
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               probes_in = probes_ff + IDX_W'(1);
            end
         end
         S_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               rsp.done = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      probes_ff <= probes_in;
      key_ff    <= key_in;
      create_ff <= create_in;
      room_ff   <= room_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
`default_nettype wire
